// ===== sv/pip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types for the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Per-edge qualifiers, produced next to the products
    typedef struct packed {
        logic valid;   // edge is tested: enabled, not horizontal, query y in span
        logic dy_pos;  // edge runs upward (y2 > y1)
    } t_edge_flags;

endpackage

// ===== sv/pip_edge_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge_mul
// Span test and cross products for one polygon edge against the query point.
// ----------------------------------------------------------------------------
module pip_edge_mul
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_en,
    input  logic signed [COORD_BITS-1:0]          i_x1,
    input  logic signed [COORD_BITS-1:0]          i_y1,
    input  logic signed [COORD_BITS-1:0]          i_x2,
    input  logic signed [COORD_BITS-1:0]          i_y2,
    input  logic signed [COORD_BITS-1:0]          i_qx,
    input  logic signed [COORD_BITS-1:0]          i_qy,
    output t_edge_flags                           o_flags,
    output logic signed [2*(COORD_BITS+1)-1:0]    o_lhs,
    output logic signed [2*(COORD_BITS+1)-1:0]    o_rhs
);

    localparam int D = COORD_BITS + 1;

    logic signed [D-1:0]          dqy;
    logic signed [D-1:0]          dx;
    logic signed [D-1:0]          dqx;
    logic signed [D-1:0]          dy;
    logic signed [COORD_BITS-1:0] lo;
    logic signed [COORD_BITS-1:0] hi;

    // Differences, one bit wider so they never wrap
    assign dqy = {i_qy[COORD_BITS-1], i_qy} - {i_y1[COORD_BITS-1], i_y1};
    assign dx  = {i_x2[COORD_BITS-1], i_x2} - {i_x1[COORD_BITS-1], i_x1};
    assign dqx = {i_qx[COORD_BITS-1], i_qx} - {i_x1[COORD_BITS-1], i_x1};
    assign dy  = {i_y2[COORD_BITS-1], i_y2} - {i_y1[COORD_BITS-1], i_y1};

    // Half-open y span of the edge
    assign lo = (i_y1 < i_y2) ? i_y1 : i_y2;
    assign hi = (i_y1 < i_y2) ? i_y2 : i_y1;

    assign o_flags.valid  = i_en && (i_y1 != i_y2) && (i_qy >= lo) && (i_qy < hi);
    assign o_flags.dy_pos = i_y2 > i_y1;

    // Crossing x right of qx  <=>  (qy-y1)*dx vs (qx-x1)*dy, direction by sign of dy
    assign o_lhs = dqy * dx;
    assign o_rhs = dqx * dy;

endmodule

// ===== sv/pip_crossing_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_crossing_acc
// Product compare for both edges and the saturating crossing counter.
// ----------------------------------------------------------------------------
module pip_crossing_acc
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_go,
    input  logic                                  i_first,
    input  t_edge_flags                           i_flags_a,
    input  logic signed [2*(COORD_BITS+1)-1:0]    i_lhs_a,
    input  logic signed [2*(COORD_BITS+1)-1:0]    i_rhs_a,
    input  t_edge_flags                           i_flags_b,
    input  logic signed [2*(COORD_BITS+1)-1:0]    i_lhs_b,
    input  logic signed [2*(COORD_BITS+1)-1:0]    i_rhs_b,
    output logic        [COUNT_BITS-1:0]          o_count_next
);

    localparam int P = 2 * (COORD_BITS + 1);

    logic signed [P:0]         diff_a;
    logic signed [P:0]         diff_b;
    logic                      hit_a;
    logic                      hit_b;
    logic [COUNT_BITS-1:0]     base;
    logic [COUNT_BITS:0]       sum;
    logic [COUNT_BITS-1:0]     r_count;
    logic [COUNT_BITS-1:0]     n_count;

    // Exact sign of lhs - rhs
    assign diff_a = {i_lhs_a[P-1], i_lhs_a} - {i_rhs_a[P-1], i_rhs_a};
    assign diff_b = {i_lhs_b[P-1], i_lhs_b} - {i_rhs_b[P-1], i_rhs_b};

    assign hit_a = i_flags_a.valid &&
                   (i_flags_a.dy_pos ? (diff_a > 0) : (diff_a < 0));
    assign hit_b = i_flags_b.valid &&
                   (i_flags_b.dy_pos ? (diff_b > 0) : (diff_b < 0));

    // A first vertex restarts the count; add up to two hits, hold at full scale
    always_comb begin
        base = i_first ? '0 : r_count;
        sum  = {1'b0, base} + (COUNT_BITS+1)'(hit_a) + (COUNT_BITS+1)'(hit_b);
        if (sum[COUNT_BITS]) begin
            n_count = '1;
        end else begin
            n_count = sum[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_go) begin
            r_count <= n_count;
        end
    end

    assign o_count_next = n_count;

endmodule

// ===== sv/point_in_polygon_crossing_test.sv =====
`timescale 1ns / 1ps
// After the last vertex is taken, its result passes the input register, the product
// register and the result register to the master side. Throughput: one vertex per cycle
// while no result waits there; each holds one item and moves on when the next has room.
// Reset (synchronous, active low) clears the held query point, the first and previous
// vertex, the crossing counter and all valid flags.
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Ray-casting crossing-number test with one polygon vertex per input item.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // query_x, query_y, vertex_x, vertex_y (lowest bits first), zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    input  logic                                    s_axis_tuser,   // first_vertex
    input  logic                                    s_axis_tlast,   // last_vertex
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // crossing_count (lowest bits), zero padded
    output logic [((COUNT_BITS+7)/8)*8-1:0]         m_axis_tdata,
    output logic                                    m_axis_tuser,   // inside_res
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready
);

    localparam int P     = 2 * (COORD_BITS + 1);
    localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8;

    // Input register
    logic                         r_iv;
    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_vx, r_vy;
    logic                         r_first, r_last;

    // Polygon state
    logic signed [COORD_BITS-1:0] r_start_x, r_start_y, r_prev_x, r_prev_y;
    logic signed [COORD_BITS-1:0] r_held_qx, r_held_qy;

    // Product register
    logic                         r_pv, r_p_first, r_p_last;
    t_edge_flags                  r_p_flags_a, r_p_flags_b;
    logic signed [P-1:0]          r_p_lhs_a, r_p_rhs_a, r_p_lhs_b, r_p_rhs_b;

    // Result register
    logic                         r_ov;
    logic [COUNT_BITS-1:0]        r_o_count;

    logic                         out_free, p_go, p_free, i_go, accept;
    logic signed [COORD_BITS-1:0] q_x, q_y, st_x, st_y;
    t_edge_flags                  flags_a, flags_b;
    logic signed [P-1:0]          lhs_a, rhs_a, lhs_b, rhs_b;
    logic [COUNT_BITS-1:0]        count_next;

    // Stage handshakes: an item without a result never waits on the master side
    assign out_free      = !r_ov || m_axis_tready;
    assign p_go          = r_pv && (!r_p_last || out_free);
    assign p_free        = !r_pv || p_go;
    assign i_go          = r_iv && p_free;
    assign s_axis_tready = !r_iv || p_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (s_axis_tready) begin
            r_iv <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qx    <= s_axis_tdata[COORD_BITS-1:0];
            r_qy    <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            r_vx    <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
            r_vy    <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
            r_first <= s_axis_tuser;
            r_last  <= s_axis_tlast;
        end
    end

    // Query point and start vertex as seen by this item
    assign q_x  = r_first ? r_qx : r_held_qx;
    assign q_y  = r_first ? r_qy : r_held_qy;
    assign st_x = r_first ? r_vx : r_start_x;
    assign st_y = r_first ? r_vy : r_start_y;

    // Edge from the previous vertex
    pip_edge_mul #(.COORD_BITS(COORD_BITS)) u_edge_prev (
        .i_en    (!r_first),
        .i_x1    (r_prev_x),
        .i_y1    (r_prev_y),
        .i_x2    (r_vx),
        .i_y2    (r_vy),
        .i_qx    (q_x),
        .i_qy    (q_y),
        .o_flags (flags_a),
        .o_lhs   (lhs_a),
        .o_rhs   (rhs_a)
    );

    // Closing edge back to the first vertex
    pip_edge_mul #(.COORD_BITS(COORD_BITS)) u_edge_close (
        .i_en    (r_last),
        .i_x1    (r_vx),
        .i_y1    (r_vy),
        .i_x2    (st_x),
        .i_y2    (st_y),
        .i_qx    (q_x),
        .i_qy    (q_y),
        .o_flags (flags_b),
        .o_lhs   (lhs_b),
        .o_rhs   (rhs_b)
    );

    // Polygon state follows the item as it leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_held_qx <= '0;
            r_held_qy <= '0;
        end else if (i_go) begin
            r_prev_x <= r_vx;
            r_prev_y <= r_vy;
            if (r_first) begin
                r_start_x <= r_vx;
                r_start_y <= r_vy;
                r_held_qx <= r_qx;
                r_held_qy <= r_qy;
            end
        end
    end

    // Product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (p_free) begin
            r_pv <= r_iv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_p_first   <= r_first;
            r_p_last    <= r_last;
            r_p_flags_a <= flags_a;
            r_p_flags_b <= flags_b;
            r_p_lhs_a   <= lhs_a;
            r_p_rhs_a   <= rhs_a;
            r_p_lhs_b   <= lhs_b;
            r_p_rhs_b   <= rhs_b;
        end
    end

    // Compare and count
    pip_crossing_acc #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (p_go),
        .i_first      (r_p_first),
        .i_flags_a    (r_p_flags_a),
        .i_lhs_a      (r_p_lhs_a),
        .i_rhs_a      (r_p_rhs_a),
        .i_flags_b    (r_p_flags_b),
        .i_lhs_b      (r_p_lhs_b),
        .i_rhs_b      (r_p_rhs_b),
        .o_count_next (count_next)
    );

    // Result register, loaded on the last vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= p_go && r_p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && p_go && r_p_last) begin
            r_o_count <= count_next;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_count[0];
    assign m_axis_tdata  = OUT_W'(r_o_count);

endmodule
